// ===== rtl/core/iwr_pkg.sv =====
package iwr_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 128;
   localparam int ADDR_WIDTH           = 48;
   localparam int OP_WIDTH             = 2;
   localparam int RETIRE_WIDTH_BITS    = 4;
   localparam int OCC_WIDTH            = 8;
   localparam int CSR_DATA_WIDTH       = 32;
   localparam int CSR_ADDR_WIDTH       = 2;

   localparam logic [RETIRE_WIDTH_BITS-1:0] MAX_RETIRE         = 4'd8;
   localparam logic [RETIRE_WIDTH_BITS-1:0] RETIRE_WIDTH_RESET = 4'd4;

   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_RETIRE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_WAKEUP = 2'd2;

   localparam logic [CSR_ADDR_WIDTH-1:0] REG_RETIRE_WIDTH = 2'd0;

   typedef enum logic {
      ST_IDLE,
      ST_RETIRE
   } state_type;

   typedef struct packed {
      logic                  insert;
      logic                  shift;
      logic                  wakeup;
      logic                  ready_in;
      logic [ADDR_WIDTH-1:0] address;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/iwr_if.sv =====
interface iwr_req_if;
   logic                            valid;
   logic                            ready;
   logic [iwr_pkg::OP_WIDTH-1:0]    op;
   logic                            entry_ready;
   logic [iwr_pkg::ADDR_WIDTH-1:0]  address;

   modport source (output valid, op, entry_ready, address, input ready);
   modport sink   (input valid, op, entry_ready, address, output ready);
endinterface

interface iwr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [iwr_pkg::RETIRE_WIDTH_BITS-1:0]  retired_count;
   logic [iwr_pkg::OCC_WIDTH-1:0]          occupancy;
   logic                                   is_full;
   logic                                   insert_dropped;

   modport source (output valid, retired_count, occupancy, is_full, insert_dropped,
                   input ready);
   modport sink   (input valid, retired_count, occupancy, is_full, insert_dropped,
                   output ready);
endinterface

// ===== rtl/core/instruction_window_retire_core.sv =====
// Instruction window with in-order retire. Entries live in a row of cells,
// the oldest in cell 0; an insert fills the first free cell and a wakeup
// compares every occupied cell against the item's address at once. A retire
// shifts the whole row down by one cell per cycle while the oldest entry is
// ready and the retire width (saturated to 8) is not reached. One item is in
// work at a time; the result sits in an output register and the next item is
// taken as soon as that register is free or being emptied. retire_width is at
// byte address 0 and resets to 4.
module instruction_window_retire_core #(
   parameter int WINDOW_DEPTH = iwr_pkg::WINDOW_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   iwr_req_if.sink                              req_chan,
   iwr_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [iwr_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [iwr_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [iwr_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                 csr_pready
);
   import iwr_pkg::*;

   localparam int CW = $clog2(WINDOW_DEPTH + 1);

   state_type                    state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [RETIRE_WIDTH_BITS-1:0] retired_ff, retired_in;
   logic [RETIRE_WIDTH_BITS-1:0] limit_ff, limit_in;
   logic [RETIRE_WIDTH_BITS-1:0] retire_width_ff, retire_width_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RETIRE_WIDTH_BITS-1:0] rsp_retired_ff, rsp_retired_in;
   logic [OCC_WIDTH-1:0]         rsp_occ_ff, rsp_occ_in;
   logic                         rsp_full_ff, rsp_full_in;
   logic                         rsp_dropped_ff, rsp_dropped_in;

   logic          slot_free, accept, full, can_step, finish;
   logic          csr_write;
   cell_ctrl_type cell_ctrl;

   logic                  cell_valid   [WINDOW_DEPTH];
   logic                  cell_ready   [WINDOW_DEPTH];
   logic [ADDR_WIDTH-1:0] cell_address [WINDOW_DEPTH];

   // configuration
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      retire_width_in = retire_width_ff;
      if (csr_write && (csr_paddr == REG_RETIRE_WIDTH)) begin
         retire_width_in = csr_pwdata[RETIRE_WIDTH_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == REG_RETIRE_WIDTH) begin
         csr_prdata = CSR_DATA_WIDTH'(retire_width_ff);
      end
   end

   // control
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign full      = (count_ff == CW'(WINDOW_DEPTH));
   assign accept    = req_chan.valid && req_chan.ready;
   assign can_step  = (state_ff == ST_RETIRE) && cell_valid[0] && cell_ready[0]
                      && (retired_ff < limit_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.op == OP_RETIRE)) begin
               state_in = ST_RETIRE;
            end
         end
         ST_RETIRE: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready     = 1'b0;
      finish             = 1'b0;
      cell_ctrl.insert   = 1'b0;
      cell_ctrl.shift    = 1'b0;
      cell_ctrl.wakeup   = 1'b0;
      cell_ctrl.ready_in = req_chan.entry_ready;
      cell_ctrl.address  = req_chan.address;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready   = slot_free;
            cell_ctrl.insert = accept && (req_chan.op == OP_INSERT) && !full;
            cell_ctrl.wakeup = accept && (req_chan.op == OP_WAKEUP);
         end
         ST_RETIRE: begin
            cell_ctrl.shift = can_step;
            finish          = !can_step && slot_free;
         end
         default: begin
            req_chan.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      retired_in = retired_ff;
      limit_in   = limit_ff;
      if (cell_ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (cell_ctrl.shift) begin
         count_in = count_ff - CW'(1);
      end
      if (accept) begin
         retired_in = '0;
         limit_in   = (retire_width_ff > MAX_RETIRE) ? MAX_RETIRE : retire_width_ff;
      end else if (cell_ctrl.shift) begin
         retired_in = retired_ff + RETIRE_WIDTH_BITS'(1);
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_retired_in = rsp_retired_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_full_in    = rsp_full_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (accept && (req_chan.op != OP_RETIRE)) begin
         rsp_valid_in   = 1'b1;
         rsp_retired_in = '0;
         rsp_occ_in     = OCC_WIDTH'(count_in);
         rsp_full_in    = (count_in == CW'(WINDOW_DEPTH));
         rsp_dropped_in = (req_chan.op == OP_INSERT) && full;
      end else if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_retired_in = retired_ff;
         rsp_occ_in     = OCC_WIDTH'(count_ff);
         rsp_full_in    = full;
         rsp_dropped_in = 1'b0;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         retired_ff      <= '0;
         limit_ff        <= '0;
         retire_width_ff <= RETIRE_WIDTH_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         retired_ff      <= retired_in;
         limit_ff        <= limit_in;
         retire_width_ff <= retire_width_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_retired_ff <= rsp_retired_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_full_ff    <= rsp_full_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.retired_count  = rsp_retired_ff;
   assign rsp_chan.occupancy      = rsp_occ_ff;
   assign rsp_chan.is_full        = rsp_full_ff;
   assign rsp_chan.insert_dropped = rsp_dropped_ff;

   // cell row, oldest entry in cell 0
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic                  prev_valid;
      logic                  next_valid;
      logic                  next_ready;
      logic [ADDR_WIDTH-1:0] next_address;

      if (i == 0) begin : g_first
         assign prev_valid = 1'b1;
      end else begin : g_prev
         assign prev_valid = cell_valid[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign next_valid   = 1'b0;
         assign next_ready   = 1'b0;
         assign next_address = '0;
      end else begin : g_next
         assign next_valid   = cell_valid[i+1];
         assign next_ready   = cell_ready[i+1];
         assign next_address = cell_address[i+1];
      end

      iwr_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl),
         .prev_valid   (prev_valid),
         .next_valid   (next_valid),
         .next_ready   (next_ready),
         .next_address (next_address),
         .valid        (cell_valid[i]),
         .ready        (cell_ready[i]),
         .address      (cell_address[i])
      );
   end

endmodule

// ===== rtl/core/iwr_cell.sv =====
module iwr_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  iwr_pkg::cell_ctrl_type        ctrl,
   input  logic                          prev_valid,
   input  logic                          next_valid,
   input  logic                          next_ready,
   input  logic [iwr_pkg::ADDR_WIDTH-1:0] next_address,
   output logic                          valid,
   output logic                          ready,
   output logic [iwr_pkg::ADDR_WIDTH-1:0] address
);
   import iwr_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  ready_ff, ready_in;
   logic [ADDR_WIDTH-1:0] address_ff, address_in;

   always_comb begin
      valid_in   = valid_ff;
      ready_in   = ready_ff;
      address_in = address_ff;
      if (ctrl.shift) begin
         valid_in   = next_valid;
         ready_in   = next_ready;
         address_in = next_address;
      end else if (ctrl.insert && !valid_ff && prev_valid) begin
         valid_in   = 1'b1;
         ready_in   = ctrl.ready_in;
         address_in = ctrl.address;
      end else if (ctrl.wakeup && valid_ff && (address_ff == ctrl.address)) begin
         ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ready_ff <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      address_ff <= address_in;
   end

   assign valid   = valid_ff;
   assign ready   = ready_ff;
   assign address = address_ff;

endmodule

// ===== verif/instruction_window_retire_core_test.sv =====
module instruction_window_retire_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import iwr_pkg::*;

   localparam int DEPTH = WINDOW_DEPTH_DEFAULT;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic                  entry_ready;
      logic [ADDR_WIDTH-1:0] address;
   } window_item_type;

   typedef struct packed {
      logic [RETIRE_WIDTH_BITS-1:0] retired_count;
      logic [OCC_WIDTH-1:0]         occupancy;
      logic                         is_full;
      logic                         insert_dropped;
   } window_status_type;

   logic clock;
   logic reset;
   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   iwr_req_if req_if ();
   iwr_rsp_if rsp_if ();

   instruction_window_retire_core #(
      .WINDOW_DEPTH(DEPTH)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_if),
      .rsp_chan   (rsp_if),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // window model
   logic                         win_ready [DEPTH];
   logic [ADDR_WIDTH-1:0]        win_addr  [DEPTH];
   int                           win_head;
   int                           win_tail;
   int                           win_count;
   logic [RETIRE_WIDTH_BITS-1:0] cfg_retire_width;

   window_item_type   pending_items[$];
   window_status_type expected_results[$];
   window_item_type   next_item;
   window_status_type oldest_status;
   logic [ADDR_WIDTH-1:0] addr_pool [8];

   int error_count;
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_span;
   logic [1:0] stall_phase;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic window_status_type predict_window(input window_item_type it);
      window_status_type r;
      int lim;
      int idx;
      r = '0;
      case (it.op)
         OP_INSERT: begin
            if (win_count >= DEPTH) begin
               r.insert_dropped = 1'b1;
            end else begin
               win_ready[win_head] = it.entry_ready;
               win_addr[win_head]  = it.address;
               win_head  = (win_head + 1) % DEPTH;
               win_count = win_count + 1;
            end
         end
         OP_RETIRE: begin
            lim = (cfg_retire_width > MAX_RETIRE) ? int'(MAX_RETIRE) : int'(cfg_retire_width);
            while (win_count > 0 && int'(r.retired_count) < lim && win_ready[win_tail]) begin
               win_tail  = (win_tail + 1) % DEPTH;
               win_count = win_count - 1;
               r.retired_count = r.retired_count + 1'b1;
            end
         end
         OP_WAKEUP: begin
            idx = win_tail;
            for (int i = 0; i < win_count; i++) begin
               if (win_addr[idx] == it.address) win_ready[idx] = 1'b1;
               idx = (idx + 1) % DEPTH;
            end
         end
         default: ;
      endcase
      r.occupancy = OCC_WIDTH'(win_count);
      r.is_full   = (win_count == DEPTH);
      return r;
   endfunction

   task automatic check_field(input string field, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t %s expected %0d actual %0d", $time, field, want, got);
      end
   endtask

   // sender: bursts with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left   <= $urandom_range(1, 24);
         gap_left     <= 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_results.insert(expected_results.size(), predict_window(
               window_item_type'{req_if.op, req_if.entry_ready, req_if.address}));
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left     <= gap_left - 1;
               req_if.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               next_item = pending_items.pop_front();
               req_if.op          <= next_item.op;
               req_if.entry_ready <= next_item.entry_ready;
               req_if.address     <= next_item.address;
               req_if.valid       <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_mode   <= 0;
         stall_span   <= 0;
         stall_phase  <= 2'd0;
      end else begin
         stall_phase <= stall_phase + 2'd1;
         if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 80);
         end else begin
            stall_span <= stall_span - 1;
         end
         case (stall_mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (stall_phase != 2'd0);
            default: rsp_if.ready <= ($urandom_range(0, 11) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t unexpected item: retired %0d occupancy %0d full %0b dropped %0b",
                     $time, rsp_if.retired_count, rsp_if.occupancy, rsp_if.is_full,
                     rsp_if.insert_dropped);
         end else begin
            oldest_status = expected_results.pop_front();
            check_field("retired_count", oldest_status.retired_count, rsp_if.retired_count);
            check_field("occupancy", oldest_status.occupancy, rsp_if.occupancy);
            check_field("is_full", oldest_status.is_full, rsp_if.is_full);
            check_field("insert_dropped", oldest_status.insert_dropped,
                        rsp_if.insert_dropped);
         end
      end
   end

   function automatic logic [ADDR_WIDTH-1:0] rand_addr();
      logic [63:0] w;
      w = {$urandom, $urandom};
      return w[ADDR_WIDTH-1:0];
   endfunction

   function automatic logic [ADDR_WIDTH-1:0] pick_addr();
      if ($urandom_range(0, 3) == 0) return rand_addr();
      return addr_pool[$urandom_range(0, 7)];
   endfunction

   task automatic add_item(input logic [OP_WIDTH-1:0] op, input logic rdy,
                           input logic [ADDR_WIDTH-1:0] addr);
      pending_items.insert(pending_items.size(), window_item_type'{op, rdy, addr});
   endtask

   // weights in percent; whatever is left over after noise goes to wakeup
   task automatic add_mixed(input int count, input int ins_pct, input int ret_pct);
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3)
            add_item(OP_UNUSED, 1'($urandom_range(0, 1)), rand_addr());
         else if (r < 3 + ins_pct)
            add_item(OP_INSERT, 1'($urandom_range(0, 1)), pick_addr());
         else if (r < 3 + ins_pct + ret_pct)
            add_item(OP_RETIRE, 1'($urandom_range(0, 1)), rand_addr());
         else
            add_item(OP_WAKEUP, 1'($urandom_range(0, 1)), pick_addr());
      end
   endtask

   task automatic wait_idle();
      while (pending_items.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_retire_width(input logic [RETIRE_WIDTH_BITS-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_WIDTH'(4 * REG_RETIRE_WIDTH);
      csr_pwdata  <= CSR_DATA_WIDTH'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cfg_retire_width = value;
      @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("[instruction_window_retire_core] ERROR");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_if.valid       = 1'b0;
      req_if.op          = OP_INSERT;
      req_if.entry_ready = 1'b0;
      req_if.address     = '0;
      rsp_if.ready       = 1'b0;
      error_count        = 0;
      win_head           = 0;
      win_tail           = 0;
      win_count          = 0;
      cfg_retire_width   = RETIRE_WIDTH_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         win_ready[i] = 1'b0;
         win_addr[i]  = '0;
      end
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      addr_pool[2] = 48'hAAAA_AAAA_AAAA;
      addr_pool[3] = 48'h5555_5555_5555;
      for (int i = 4; i < 8; i++) addr_pool[i] = rand_addr();

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed, reset retire width
      add_item(OP_RETIRE, 1'b1, '0);
      add_item(OP_WAKEUP, 1'b0, addr_pool[0]);
      add_item(OP_UNUSED, 1'b1, '1);
      add_item(OP_INSERT, 1'b1, addr_pool[0]);
      add_item(OP_INSERT, 1'b0, addr_pool[1]);
      add_item(OP_INSERT, 1'b0, addr_pool[2]);
      add_item(OP_INSERT, 1'b1, addr_pool[3]);
      add_item(OP_RETIRE, 1'b0, '0);
      add_item(OP_WAKEUP, 1'b0, addr_pool[3]);
      add_item(OP_WAKEUP, 1'b0, addr_pool[0]);   // freed slot only
      add_item(OP_RETIRE, 1'b0, '0);
      add_item(OP_WAKEUP, 1'b1, addr_pool[1]);
      add_item(OP_RETIRE, 1'b0, '0);
      add_item(OP_WAKEUP, 1'b0, addr_pool[2]);
      for (int i = 0; i < 5; i++) add_item(OP_INSERT, 1'b1, addr_pool[4 + (i % 4)]);
      add_item(OP_RETIRE, 1'b0, '1);
      add_item(OP_RETIRE, 1'b1, '0);
      add_item(OP_UNUSED, 1'b0, '0);
      add_item(OP_RETIRE, 1'b1, '1);
      wait_idle();

      write_retire_width(4'd8);
      add_mixed(120, 40, 30);
      wait_idle();

      // width zero: fill to full and past it
      write_retire_width(4'd0);
      for (int i = 0; i < 140; i++) begin
         if ($urandom_range(0, 9) == 0)
            add_mixed(1, 0, 50);
         else
            add_item(OP_INSERT, 1'($urandom_range(0, 1)), pick_addr());
      end
      add_item(OP_INSERT, 1'b1, '1);
      add_item(OP_INSERT, 1'b0, '0);
      wait_idle();

      // above eight saturates
      write_retire_width(4'd15);
      add_mixed(150, 10, 45);
      wait_idle();

      write_retire_width(4'd1);
      add_mixed(50, 45, 30);
      wait_idle();

      write_retire_width(4'd9);
      add_mixed(50, 40, 30);
      wait_idle();

      write_retire_width(4'($urandom_range(1, 15)));
      add_mixed(50, 40, 30);
      wait_idle();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("[instruction_window_retire_core] OK");
      end else begin
         $display("[instruction_window_retire_core] ERROR");
      end
      $finish;
   end

endmodule
